// ===== src/dmhpq_pkg.sv =====
// Shared types and constants for the d-ary max-heap priority queue.
package dmhpq_pkg;

   localparam int VALUE_W       = 32;
   localparam int ARITY_W       = 4;
   localparam int ENTRY_COUNT_W = 11;
   localparam int STATUS_W      = 2;
   localparam int RSP_DATA_W    = 80;
   localparam logic [ARITY_W-1:0] DEFAULT_ARITY = 4'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_FULL,
      OP_SET_EMPTY,
      OP_INS_START,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_RD_PAR,
      OP_UP_MOVE,
      OP_WR_VAL,
      OP_RD_ROOT,
      OP_TAKE_ROOT,
      OP_TAKE_LAST,
      OP_DN_FIRST,
      OP_DN_RD,
      OP_DN_CMP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      dn_move;
      logic      out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_remove;
      logic full;
      logic count_zero;
      logic pos_zero;
      logic div_last;
      logic up_greater;
      logic first_ge_n;
      logic child_more;
      logic down_go;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/dmhpq_ctrl.sv =====
// Sequencer for insert sift-up and remove sift-down.
module dmhpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  dmhpq_pkg::dp_status_type st,
   output dmhpq_pkg::dp_cmd_type   cmd
);
   import dmhpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_CHECK,
      S_DIV,
      S_RD_PAR,
      S_UP_CMP,
      S_RM_ROOT,
      S_RM_LAST,
      S_DN_FIRST,
      S_DN_CHK,
      S_DN_RD,
      S_DN_CMP,
      S_DN_DEC,
      S_FIN,
      S_FIN_WAIT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.dn_move  = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!st.is_remove) begin
               if (st.full) begin
                  cmd.op   = OP_SET_FULL;
                  state_in = S_FIN;
               end else begin
                  cmd.op   = OP_INS_START;
                  state_in = S_UP_CHECK;
               end
            end else if (st.count_zero) begin
               cmd.op   = OP_SET_EMPTY;
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_RD_ROOT;
               state_in = S_RM_ROOT;
            end
         end
         S_UP_CHECK: begin
            if (st.pos_zero) begin
               cmd.op   = OP_WR_VAL;
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_DIV_START;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (st.div_last) state_in = S_RD_PAR;
         end
         S_RD_PAR: begin
            cmd.op   = OP_RD_PAR;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (st.up_greater) begin
               cmd.op   = OP_UP_MOVE;
               state_in = S_UP_CHECK;
            end else begin
               cmd.op   = OP_WR_VAL;
               state_in = S_FIN;
            end
         end
         S_RM_ROOT: begin
            cmd.op   = OP_TAKE_ROOT;
            state_in = S_RM_LAST;
         end
         S_RM_LAST: begin
            cmd.op   = OP_TAKE_LAST;
            state_in = st.count_zero ? S_FIN : S_DN_FIRST;
         end
         S_DN_FIRST: begin
            cmd.op   = OP_DN_FIRST;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (st.first_ge_n) begin
               cmd.op   = OP_WR_VAL;
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_DN_RD;
               state_in = S_DN_CMP;
            end
         end
         S_DN_RD: begin
            cmd.op   = OP_DN_RD;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmd.op   = OP_DN_CMP;
            state_in = st.child_more ? S_DN_RD : S_DN_DEC;
         end
         S_DN_DEC: begin
            if (st.down_go) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_FIRST;
            end else begin
               cmd.op   = OP_WR_VAL;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.op   = OP_RD_ROOT;
            state_in = S_FIN_WAIT;
         end
         S_FIN_WAIT: begin
            // The root word stays in the read register until the result slot frees up.
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/dmhpq_datapath.sv =====
// Heap store, index registers, parent divider and result register.
module dmhpq_datapath #(
   parameter int CAPACITY  = 1024,
   parameter int MAX_ARITY = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [dmhpq_pkg::ARITY_W-1:0]         csr_wr_data,
   input  logic [dmhpq_pkg::VALUE_W-1:0]         req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dmhpq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [dmhpq_pkg::STATUS_W-1:0]        rsp_tuser,
   input  dmhpq_pkg::dp_cmd_type                 cmd,
   output dmhpq_pkg::dp_status_type              st
);
   import dmhpq_pkg::*;

   localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int D_W   = $clog2(MAX_ARITY + 1);
   localparam int FW    = IDX_W + 5;
   localparam int DC_W  = $clog2(IDX_W + 1);

   logic [VALUE_W-1:0] heap_mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [ARITY_W-1:0] arity_ff;
   logic [D_W-1:0]     d_eff;
   logic               kind_ff;
   logic [VALUE_W-1:0] val_ff, bestval_ff, removed_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   pos_ff, best_ff, div_quo_ff;
   logic [D_W-1:0]     div_rem_ff;
   logic [DC_W-1:0]    div_cnt_ff;
   logic [FW-1:0]      first_ff, cidx_ff, cidx_nxt, first_in;
   logic [D_W:0]       rem_sh;
   logic [IDX_W:0]     quo_sh;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [VALUE_W-1:0]    top_value;

   always_comb begin
      if ({1'b0, arity_ff} < 5'd2) begin
         d_eff = D_W'(2);
      end else if (32'(arity_ff) > 32'(MAX_ARITY)) begin
         d_eff = D_W'(MAX_ARITY);
      end else begin
         d_eff = D_W'(arity_ff);
      end
   end

   assign cidx_nxt = cidx_ff + FW'(1);
   assign first_in = FW'(pos_ff) * FW'(d_eff) + FW'(1);
   assign rem_sh   = {div_rem_ff, div_quo_ff[IDX_W-1]};
   assign quo_sh   = {div_quo_ff, (rem_sh >= {1'b0, d_eff})};
   assign top_value = (count_ff != '0) ? rd_data_ff : '0;

   always_comb begin
      st.is_remove  = kind_ff;
      st.full       = (count_ff == CNT_W'(CAPACITY));
      st.count_zero = (count_ff == '0);
      st.pos_zero   = (pos_ff == '0);
      st.div_last   = (div_cnt_ff == DC_W'(IDX_W - 1));
      st.up_greater = ($signed(val_ff) > $signed(rd_data_ff));
      st.first_ge_n = (first_ff >= FW'(count_ff));
      st.child_more = (cidx_nxt < FW'(count_ff)) && ((cidx_nxt - first_ff) < FW'(d_eff));
      st.down_go    = ($signed(val_ff) <= $signed(bestval_ff));
      st.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = val_ff;
      case (cmd.op)
         OP_RD_PAR: begin
            rd_en   = 1'b1;
            rd_addr = div_quo_ff;
         end
         OP_RD_ROOT: rd_en = 1'b1;
         OP_TAKE_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
         end
         OP_DN_RD: begin
            rd_en   = 1'b1;
            rd_addr = cidx_ff[IDX_W-1:0];
         end
         OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
         end
         OP_WR_VAL: wr_en = 1'b1;
         default: ;
      endcase
      if (cmd.dn_move) begin
         wr_en   = 1'b1;
         wr_data = bestval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= heap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arity_ff     <= DEFAULT_ARITY;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) arity_ff <= csr_wr_data;
         case (cmd.op)
            OP_INS_START: count_ff <= count_ff + CNT_W'(1);
            OP_TAKE_ROOT: count_ff <= count_ff - CNT_W'(1);
            default: ;
         endcase
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            kind_ff    <= req_tuser;
            val_ff     <= req_tdata;
            status_ff  <= STATUS_OK;
            removed_ff <= '0;
         end
         OP_SET_FULL:  status_ff <= STATUS_FULL;
         OP_SET_EMPTY: status_ff <= STATUS_EMPTY;
         OP_INS_START: pos_ff <= count_ff[IDX_W-1:0];
         OP_DIV_START: begin
            div_quo_ff <= pos_ff - IDX_W'(1);
            div_rem_ff <= '0;
            div_cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            // Restoring division, one quotient bit per cycle.
            div_quo_ff <= quo_sh[IDX_W-1:0];
            div_rem_ff <= (rem_sh >= {1'b0, d_eff}) ? D_W'(rem_sh - {1'b0, d_eff})
                                                     : D_W'(rem_sh);
            div_cnt_ff <= div_cnt_ff + DC_W'(1);
         end
         OP_UP_MOVE:   pos_ff <= div_quo_ff;
         OP_TAKE_ROOT: removed_ff <= rd_data_ff;
         OP_TAKE_LAST: begin
            val_ff <= rd_data_ff;
            pos_ff <= '0;
         end
         OP_DN_FIRST: begin
            first_ff <= first_in;
            cidx_ff  <= first_in;
         end
         OP_DN_CMP: begin
            if (cidx_ff == first_ff || $signed(rd_data_ff) > $signed(bestval_ff)) begin
               best_ff    <= cidx_ff[IDX_W-1:0];
               bestval_ff <= rd_data_ff;
            end
            cidx_ff <= cidx_nxt;
         end
         default: ;
      endcase
      if (cmd.dn_move) pos_ff <= best_ff;
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {5'd0, ENTRY_COUNT_W'(count_ff), top_value, removed_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== src/dary_max_heap_priority_queue_top.sv =====
// Top level of the d-ary max-heap priority queue.
//
// Request words arrive on req_*: tuser selects insert (0) or remove (1),
// tdata carries the signed 32-bit key for an insert. Every request gives
// exactly one response word on rsp_*: tuser holds the status (ok, remove
// from empty, insert into full), tdata the removed key, the new top and
// the entry count. csr_wr_en/csr_wr_data set the arity; the user must write
// it only while idle, as the block itself does not enforce this. Requests
// are handled one at a time. An insert compares the new key with one parent
// after another, and each parent index comes from a bit-serial divider. A
// remove compares the children of one node after another, one child read
// at a time through the single read port of the heap memory.
// A finished response waits in an output register; the block takes the
// next request while it waits, and only stalls finishing a second one.
// Reset empties the queue and sets the arity to 2; the heap memory is not
// cleared: an empty queue reports zero as its top, and no slot's stale word is used.
module dary_max_heap_priority_queue_top #(
   parameter int CAPACITY  = 1024,
   parameter int MAX_ARITY = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,   // arity
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // value
   input  logic        req_tuser,     // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,     // removed_value, top_value, entry_count, zero fill
   output logic [1:0]  rsp_tuser      // status
);
   import dmhpq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   dmhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   dmhpq_datapath #(
      .CAPACITY  (CAPACITY),
      .MAX_ARITY (MAX_ARITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .st          (st)
   );

endmodule
